>>> rtl/mlpq_pkg.sv
`timescale 1ns / 1ps

package mlpq_pkg;

  // Default sizing
  localparam int LEVELS_DEF = 8;
  localparam int DEPTH_DEF  = 16;

  // Configuration register widths and reset values
  localparam int ACT_W     = 4;
  localparam int CAP_W     = 5;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_CAPACITY = 2'd1;

  // Operation codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Payload widths
  localparam int WORD_W  = 32;
  localparam int LEVEL_W = 4;

  typedef enum logic [2:0] {
    STAT_ENQ = 3'd0,
    STAT_DEQ = 3'd1,
    STAT_OVF = 3'd2,
    STAT_UNF = 3'd3,
    STAT_BAD = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PTR,
    S_SLOT,
    S_RES
  } state_t;

  // Update of the per-level nonempty flags
  typedef struct packed {
    logic set;
    logic clr;
  } flag_ctl_t;

endpackage

>>> rtl/multi_level_priority_queue.sv
`timescale 1ns / 1ps
// Path from input transfer to result valid: invalid level or underflow goes to S_RES,
// enqueue or overflow through S_PTR and S_RES, dequeue through S_PTR, S_SLOT and S_RES.
// One item at a time: no new item is taken until the last result is in the output register;
// the path is set by the pointer memory read followed by the slot memory read.
// Reset clears the FSM, the output valid and the level flags and loads active_levels 8,
// queue_capacity 16; the slot and pointer memories are not cleared (flags gate them).

module multi_level_priority_queue #(
  parameter int LEVELS = mlpq_pkg::LEVELS_DEF,
  parameter int DEPTH  = mlpq_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // level[3:0], data[35:4], zero pad
  input  logic [0:0]                     s_axis_tuser,  // func[0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,  // out_data[31:0], served_level[35:32]
  output logic [2:0]                     m_axis_tuser,  // status[2:0]
  input  logic                           cfg_we,
  input  logic [mlpq_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [mlpq_pkg::CFG_W-1:0]     cfg_wdata
);
  import mlpq_pkg::*;

  localparam int LW      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRIES = LEVELS * DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_t state, state_next;

  // Configuration
  logic [ACT_W-1:0] act_levels;
  logic [CAP_W-1:0] queue_cap;
  logic [LW:0]      nlev;
  logic [DW:0]      cap_eff;

  // Item in flight
  logic              op_deq;
  logic [LW-1:0]     q;
  logic [WORD_W-1:0] word;
  status_t           res_status;
  logic [WORD_W-1:0] res_data;
  logic [LEVEL_W-1:0] res_level;

  // Output register
  logic               m_valid;
  status_t            m_status;
  logic [WORD_W-1:0]  m_data;
  logic [LEVEL_W-1:0] m_level;

  // Input fields
  logic               in_func;
  logic [LEVEL_W-1:0] in_level;
  logic [WORD_W-1:0]  in_data;
  logic               in_xfer;
  logic               lvl_ok;
  logic [LW-1:0]      q_in;

  // Memories and flags
  logic              ptr_we;
  logic [LW-1:0]     ptr_raddr;
  logic [2*DW-1:0]   ptr_wdata, ptr_rdata;
  logic              slot_we;
  logic [AW-1:0]     slot_waddr, slot_raddr;
  logic [WORD_W-1:0] slot_rdata;
  flag_ctl_t         flag_ctl;
  logic              flag_q, found;
  logic [LW-1:0]     first;

  logic [DW-1:0] head, tail;
  logic [DW:0]   tail_inc;
  logic [AW-1:0] base;
  status_t       calc_status;
  logic          out_free;

  assign in_func  = s_axis_tuser[0];
  assign in_level = s_axis_tdata[3:0];
  assign in_data  = s_axis_tdata[35:4];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;

  // Clamp configuration to the built sizes
  always_comb begin
    nlev = (32'(act_levels) > LEVELS) ? (LW+1)'(LEVELS) : (LW+1)'(act_levels);
    if (queue_cap == '0) begin
      cap_eff = (DW+1)'(1);
    end else if (32'(queue_cap) > DEPTH) begin
      cap_eff = (DW+1)'(DEPTH);
    end else begin
      cap_eff = (DW+1)'(queue_cap);
    end
  end

  assign lvl_ok = (in_level != '0) && (32'(in_level) <= 32'(nlev));
  assign q_in   = LW'(32'(in_level) - 32'd1);

  assign head     = ptr_rdata[2*DW-1:DW];
  assign tail     = ptr_rdata[DW-1:0];
  assign tail_inc = (DW+1)'(tail) + (DW+1)'(1);
  assign base     = AW'(32'(q) * DEPTH);
  assign out_free = !m_valid || m_axis_tready;

  mlpq_ram #(.WIDTH(2 * DW), .ENTRIES(LEVELS)) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (q),
    .wdata (ptr_wdata),
    .raddr (ptr_raddr),
    .rdata (ptr_rdata)
  );

  mlpq_ram #(.WIDTH(WORD_W), .ENTRIES(ENTRIES)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (word),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  mlpq_sel #(.LEVELS(LEVELS)) u_sel (
    .clk    (clk),
    .rst    (rst),
    .ctl    (flag_ctl),
    .idx    (q),
    .lim    (nlev),
    .flag_q (flag_q),
    .found  (found),
    .first  (first)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_func == FUNC_DEQ) begin
            state_next = found ? S_PTR : S_RES;
          end else begin
            state_next = lvl_ok ? S_PTR : S_RES;
          end
        end
      end
      S_PTR:   state_next = op_deq ? S_SLOT : S_RES;
      S_SLOT:  state_next = S_RES;
      S_RES:   state_next = out_free ? S_IDLE : S_RES;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory, flag and handshake controls
  always_comb begin
    s_axis_tready = 1'b0;
    ptr_raddr     = (in_func == FUNC_DEQ) ? first : q_in;
    ptr_we        = 1'b0;
    ptr_wdata     = ptr_rdata;
    slot_we       = 1'b0;
    slot_waddr    = base;
    slot_raddr    = base + AW'(head);
    flag_ctl      = '0;
    calc_status   = STAT_DEQ;
    case (state)
      S_IDLE: s_axis_tready = 1'b1;
      S_PTR: begin
        if (op_deq) begin
          // Pop the head; drop the level when it empties
          if (head == tail) begin
            flag_ctl.clr = 1'b1;
          end else begin
            ptr_we    = 1'b1;
            ptr_wdata = {head + DW'(1), tail};
          end
        end else if (!flag_q) begin
          // First word restarts the queue at slot zero
          slot_we      = 1'b1;
          ptr_we       = 1'b1;
          ptr_wdata    = '0;
          flag_ctl.set = 1'b1;
          calc_status  = STAT_ENQ;
        end else if (tail_inc < cap_eff) begin
          slot_we     = 1'b1;
          slot_waddr  = base + AW'(tail_inc);
          ptr_we      = 1'b1;
          ptr_wdata   = {head, tail_inc[DW-1:0]};
          calc_status = STAT_ENQ;
        end else begin
          calc_status = STAT_OVF;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_valid    <= 1'b0;
      act_levels <= ACT_RESET;
      queue_cap  <= CAP_RESET;
    end else begin
      state <= state_next;
      if (state == S_RES && out_free) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_ACTIVE_LEVELS:  act_levels <= cfg_wdata[ACT_W-1:0];
          REG_QUEUE_CAPACITY: queue_cap  <= cfg_wdata[CAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          op_deq    <= (in_func == FUNC_DEQ);
          q         <= (in_func == FUNC_DEQ) ? first : q_in;
          word      <= in_data;
          res_data  <= '0;
          res_level <= '0;
          if (in_func == FUNC_DEQ) begin
            res_status <= found ? STAT_DEQ : STAT_UNF;
          end else begin
            res_status <= lvl_ok ? STAT_ENQ : STAT_BAD;
          end
        end
      end
      S_PTR: begin
        res_status <= calc_status;
        res_level  <= op_deq ? LEVEL_W'(32'(q) + 32'd1) : '0;
      end
      S_SLOT: res_data <= slot_rdata;
      S_RES: begin
        if (out_free) begin
          m_status <= res_status;
          m_data   <= res_data;
          m_level  <= res_level;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {4'b0, m_level, m_data};
  assign m_axis_tuser  = m_status;

  // The block is never ready in the cycle after an input transfer
  assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

  // Only dequeue results carry a word and a level
  assert property (@(posedge clk) disable iff (rst)
    m_valid && (m_status != STAT_DEQ) |-> (m_data == '0) && (m_level == '0))
    else $error("non-dequeue result with payload");

  // A dequeue always names a real level
  assert property (@(posedge clk) disable iff (rst)
    m_valid && (m_status == STAT_DEQ) |-> (m_level != '0))
    else $error("dequeue without level");

  // Flags are never set and cleared together
  assert property (@(posedge clk) disable iff (rst)
    !(flag_ctl.set && flag_ctl.clr))
    else $error("flag set and clear collide");

  // Memory writes happen only while pointers are being updated
  assert property (@(posedge clk) disable iff (rst)
    (slot_we || ptr_we) |-> (state == S_PTR))
    else $error("memory write outside pointer update");

endmodule

>>> rtl/mlpq_ram.sv
`timescale 1ns / 1ps

module mlpq_ram #(
  parameter int WIDTH   = 32,
  parameter int ENTRIES = 128,
  parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [ENTRIES];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mlpq_sel.sv
`timescale 1ns / 1ps

module mlpq_sel #(
  parameter int LEVELS = mlpq_pkg::LEVELS_DEF,
  parameter int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  mlpq_pkg::flag_ctl_t ctl,
  input  logic [LW-1:0]      idx,
  input  logic [LW:0]        lim,
  output logic               flag_q,
  output logic               found,
  output logic [LW-1:0]      first
);
  import mlpq_pkg::*;

  logic [LEVELS-1:0] nonempty;

  // Set on first enqueue, clear when the last word leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
    end else if (ctl.set) begin
      nonempty[idx] <= 1'b1;
    end else if (ctl.clr) begin
      nonempty[idx] <= 1'b0;
    end
  end

  assign flag_q = nonempty[idx];

  // Lowest-numbered nonempty active level wins
  always_comb begin
    found = 1'b0;
    first = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i] && ((LW+1)'(i) < lim)) begin
        found = 1'b1;
        first = LW'(i);
      end
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import mlpq_pkg::*;

  localparam int LEVELS = LEVELS_DEF;
  localparam int DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  // Register indexes that the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] word;
    logic [3:0]        lvl;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [39:0]          s_axis_tdata = '0;
  logic [0:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;
  logic [2:0]           m_axis_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Predicted block state
  logic [WORD_W-1:0] slot_words [0:LEVELS-1][0:DEPTH-1];
  logic [3:0]        head_slot [0:LEVELS-1];
  logic [3:0]        tail_slot [0:LEVELS-1];
  bit                level_busy [0:LEVELS-1];
  logic [ACT_W-1:0]  cur_levels = ACT_RESET;
  logic [CAP_W-1:0]  cur_capacity = CAP_RESET;

  outcome_t pending_outcomes[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 10;
  int       ready_stall_pct = 10;

  // Random phase settings
  int phase_levels [0:9] = '{8, 1, 15, 3, 0, 5, 24, 2, 13, 8};
  int phase_capacity [0:9] = '{16, 1, 31, 4, 0, 2, 20, 8, 9, 16};
  int phase_enq_pct [0:9] = '{55, 70, 40, 60, 50, 80, 45, 65, 35, 55};
  int phase_items [0:9] = '{120, 110, 120, 130, 30, 110, 120, 120, 110, 120};

  multi_level_priority_queue u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99, 0) >= ready_stall_pct);
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Compare each result transfer with the oldest pending outcome
  always @(posedge clk) begin : check_result
    outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result", {29'd0, m_axis_tuser}, '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", {29'd0, m_axis_tuser}, {29'd0, want.status});
        if (m_axis_tdata[31:0] !== want.word)
          report_mismatch("out_data", m_axis_tdata[31:0], want.word);
        if (m_axis_tdata[35:32] !== want.lvl)
          report_mismatch("served_level", {28'd0, m_axis_tdata[35:32]}, {28'd0, want.lvl});
      end
    end
  end

  function automatic int level_count();
    return (cur_levels > LEVELS) ? LEVELS : int'(cur_levels);
  endfunction

  // Work out the outcome of one operation and advance the predicted queues
  task automatic queue_op_outcome(input logic func, input logic [3:0] lvl,
                                  input logic [WORD_W-1:0] word, output outcome_t res);
    int nlev;
    int cap;
    int q;
    nlev = level_count();
    cap = (cur_capacity == 0) ? 1 : ((cur_capacity > DEPTH) ? DEPTH : int'(cur_capacity));
    res.status = STAT_UNF;
    res.word = '0;
    res.lvl = '0;
    if (func == FUNC_ENQ) begin
      q = int'(lvl) - 1;
      if (lvl == 0 || int'(lvl) > nlev) begin
        res.status = STAT_BAD;
      end else if (!level_busy[q]) begin
        head_slot[q] = '0;
        tail_slot[q] = '0;
        slot_words[q][0] = word;
        level_busy[q] = 1'b1;
        res.status = STAT_ENQ;
      end else if (int'(tail_slot[q]) + 1 < cap) begin
        tail_slot[q] = tail_slot[q] + 1'b1;
        slot_words[q][tail_slot[q]] = word;
        res.status = STAT_ENQ;
      end else begin
        res.status = STAT_OVF;
      end
    end else begin
      // Serve the lowest-numbered non-empty active level
      for (int i = 0; i < nlev; i++) begin
        if (level_busy[i] && res.status == STAT_UNF) begin
          res.status = STAT_DEQ;
          res.word = slot_words[i][head_slot[i]];
          res.lvl = 4'(i + 1);
          if (head_slot[i] == tail_slot[i]) begin
            level_busy[i] = 1'b0;
            head_slot[i] = '0;
            tail_slot[i] = '0;
          end else begin
            head_slot[i] = head_slot[i] + 1'b1;
          end
        end
      end
    end
  endtask

  // Offer one item, hold it until the transfer, then record its outcome
  task automatic send_item(input logic func, input logic [3:0] lvl,
                           input logic [WORD_W-1:0] word);
    outcome_t res;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {4'b0000, word, lvl};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    queue_op_outcome(func, lvl, word, res);
    pending_outcomes.push_back(res);
  endtask

  // Drop valid and wait for every pending result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_ACTIVE_LEVELS) cur_levels = value[ACT_W-1:0];
    else if (addr == REG_QUEUE_CAPACITY) cur_capacity = value;
  endtask

  // Empty queue and out-of-range levels
  task automatic test_empty_and_bad_levels();
    send_item(FUNC_DEQ, 4'd3, 32'h1234_5678);
    send_item(FUNC_ENQ, 4'd0, 32'hDEAD_BEEF);
    send_item(FUNC_ENQ, 4'd15, 32'hFFFF_FFFF);
    send_item(FUNC_ENQ, 4'd9, 32'h0000_0001);
  endtask

  // Lower levels are served first, FIFO order within a level
  task automatic test_priority_order();
    send_item(FUNC_ENQ, 4'd8, 32'h7FFF_FFFF);
    send_item(FUNC_ENQ, 4'd1, 32'h8000_0000);
    send_item(FUNC_ENQ, 4'd1, 32'hFFFF_FFFF);
    send_item(FUNC_ENQ, 4'd4, 32'h0000_0000);
    repeat (5) send_item(FUNC_DEQ, 4'd15, 32'hAAAA_5555);
  endtask

  // Capacity of zero, lowered capacity and capacity above the depth
  task automatic test_capacity_edges();
    write_reg(REG_QUEUE_CAPACITY, 5'd0);
    send_item(FUNC_ENQ, 4'd2, 32'h0000_0011);
    send_item(FUNC_ENQ, 4'd2, 32'h0000_0022);
    write_reg(REG_QUEUE_CAPACITY, 5'd2);
    send_item(FUNC_ENQ, 4'd2, 32'h0000_0033);
    send_item(FUNC_ENQ, 4'd2, 32'h0000_0044);
    write_reg(REG_QUEUE_CAPACITY, 5'd1);
    send_item(FUNC_ENQ, 4'd2, 32'h0000_0055);
    repeat (2) send_item(FUNC_DEQ, 4'd0, 32'h0);
    write_reg(REG_QUEUE_CAPACITY, 5'd31);
  endtask

  // Zero levels, too many levels, hidden levels and spare indexes
  task automatic test_level_count_edges();
    write_reg(REG_ACTIVE_LEVELS, 5'd0);
    send_item(FUNC_ENQ, 4'd1, 32'h5A5A_5A5A);
    send_item(FUNC_DEQ, 4'd1, 32'h0);
    write_reg(REG_ACTIVE_LEVELS, 5'd15);
    send_item(FUNC_ENQ, 4'd8, 32'hC001_D00D);
    write_reg(REG_ACTIVE_LEVELS, 5'd2);
    send_item(FUNC_DEQ, 4'd0, 32'h0);
    send_item(FUNC_ENQ, 4'd8, 32'h0BAD_0BAD);
    write_reg(REG_SPARE_2, 5'd1);
    write_reg(REG_SPARE_3, 5'd31);
    write_reg(REG_ACTIVE_LEVELS, 5'd8);
    send_item(FUNC_DEQ, 4'd0, 32'h0);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(15, 0))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Random phases over many register settings, mostly valid levels
  task automatic test_random_phases();
    logic       func;
    logic [3:0] lvl;
    int         nlev;
    for (int p = 0; p < 10; p++) begin
      write_reg(REG_ACTIVE_LEVELS, CFG_W'(phase_levels[p]));
      write_reg(REG_QUEUE_CAPACITY, CFG_W'(phase_capacity[p]));
      // Hold both sides busy in phases 3 and 5
      send_idle_pct = (p == 3 || p == 5) ? 0 : 10;
      ready_stall_pct = (p == 3 || p == 5) ? 0 : 10;
      nlev = level_count();
      for (int n = 0; n < phase_items[p]; n++) begin
        func = ($urandom_range(99, 0) < phase_enq_pct[p]) ? FUNC_ENQ : FUNC_DEQ;
        if (nlev > 0 && $urandom_range(99, 0) < 85) lvl = 4'($urandom_range(nlev, 1));
        else lvl = 4'($urandom_range(15, 0));
        send_item(func, lvl, pick_word());
      end
    end
    send_idle_pct = 10;
    ready_stall_pct = 10;
  endtask

  initial begin
    for (int i = 0; i < LEVELS; i++) begin
      head_slot[i] = '0;
      tail_slot[i] = '0;
      level_busy[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_bad_levels();
    test_priority_order();
    test_capacity_edges();
    test_level_count_edges();
    test_random_phases();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mlpq_pkg.sv
rtl/mlpq_ram.sv
rtl/mlpq_sel.sv
rtl/multi_level_priority_queue.sv
test/tb.sv
